// File: hdl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 digest block.
package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } front_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } back_state_t;

  localparam word_t INITIAL_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// File: hdl/sha256_message_digest.sv
// Top level of the SHA-256 digest block: input queue plus compression engine.
//   channel | direction | beat
//   message | in        | data_word, byte_count, last_word (push/full)
//   digest  | out       | digest_word, word_index, digest_done (empty/pop)
// A block of 16 words is taken in beats, then compressed in 64 rounds and an add step;
// the single round unit sets the throughput.
// A last beat adds padding words and one or two compressions,
// then 8 digest beats; the engine takes no beat until the eighth is popped.
// Reset is synchronous and restores initial hash state.
// The input queue keeps taking beats while the engine compresses, until it is full.
module sha256_message_digest import sha256_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_done
);
  logic        item_valid, item_take;
  front_item_t item;

  sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst, .push, .full, .data_word, .byte_count, .last_word,
    .item_valid, .item, .item_take);

  sha256_back u_back (
    .clk, .rst, .item_valid, .item, .item_take,
    .empty, .pop, .digest_word, .word_index, .digest_done);
endmodule

// File: hdl/sha256_front.sv
// Input stage: accepts message beats and queues them for the compression engine.
module sha256_front import sha256_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        item_valid,
  output front_item_t item,
  input  logic        item_take
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  front_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;
  logic do_push, do_pop;

  assign full       = (fill == (AW+1)'(DEPTH));
  assign item_valid = (fill != '0);
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      // saturate counts above four
      slots[wr_ptr] <= '{data_word, (byte_count > 3'd4) ? 3'd4 : byte_count, last_word};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// File: hdl/sha256_back.sv
// Compression engine: block buffer, padding, 64 rounds per block, digest output.
module sha256_back import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  front_item_t item,
  output logic        item_take,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_done
);
  back_state_t state, state_next;
  word_t chain [8];
  word_t vars [8];
  word_t w [16];
  logic [3:0]  word_pos;
  logic [63:0] bit_len;
  logic [5:0]  round;
  logic [2:0]  emit_idx;
  logic        pad_len;     // padding in progress (after the last item)
  logic        len_stage;   // 0: append 0x80 word, 1: zeros and length
  logic        pad_done_q;  // length high word written in this block

  word_t wr_word;
  logic  wr_en;
  word_t pad_word, wt, s0w, s1w, t1, t2, ch, maj, sig0, sig1;
  logic [63:0] len_next;
  logic [5:0]  cbits;

  always_comb begin
    cbits    = {item.count, 3'b000};
    pad_word = (item.count == 3'd0) ? 32'h8000_0000 :
               (item.data & (32'hffff_ffff << (6'd32 - cbits))) |
               (32'h8000_0000 >> cbits);
  end

  always_comb begin
    s0w = rotr(w[round[3:0]+4'd1], 7) ^ rotr(w[round[3:0]+4'd1], 18) ^
          (w[round[3:0]+4'd1] >> 3);
    s1w = rotr(w[round[3:0]+4'd14], 17) ^ rotr(w[round[3:0]+4'd14], 19) ^
          (w[round[3:0]+4'd14] >> 10);
    if (round < 6'd16) begin
      wt = w[round[3:0]];
    end else begin
      wt = w[round[3:0]] + s0w + w[round[3:0]+4'd9] + s1w;
    end
    sig1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    ch   = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1   = vars[7] + sig1 + ch + ROUND_K[round] + wt;
    sig0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    maj  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t2   = sig0 + maj;
  end

  // IDLE takes an item; a last item writes its data (0x80 marker merged if under four
  // bytes), then PAD writes the 0x80 word if still due, zeros and length one word a cycle.
  always_comb begin
    state_next = state;
    item_take  = 1'b0;
    wr_en      = 1'b0;
    wr_word    = '0;
    len_next   = bit_len;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          wr_en     = 1'b1;
          if (!item.last) begin
            wr_word  = item.data;
            len_next = bit_len + 64'd32;
            if (word_pos == 4'd15) state_next = ST_ROUND;
          end else begin
            len_next = bit_len + {58'd0, cbits};
            wr_word  = (item.count == 3'd4) ? item.data : pad_word;
            if (word_pos == 4'd15) state_next = ST_ROUND;
            else state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en = 1'b1;
        if (!len_stage) wr_word = 32'h8000_0000;
        else if (word_pos == 4'd14) wr_word = bit_len[63:32];
        else if (word_pos == 4'd15 && pad_done_q) wr_word = bit_len[31:0];
        else wr_word = '0;
        if (word_pos == 4'd15) state_next = ST_ROUND;
      end
      ST_ROUND: if (round == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (!pad_len) state_next = ST_IDLE;
        else if (pad_done_q) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: begin
        if (pop && emit_idx == 3'd7) begin
          state_next = ST_IDLE;
          len_next   = '0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) w[word_pos] <= wr_word;
    if (state == ST_ROUND && round >= 6'd16) w[round[3:0]] <= wt;
    if (state == ST_IDLE && item_valid) begin
      for (int i = 0; i < 8; i++) vars[i] <= chain[i];
    end else if (state == ST_PAD && word_pos == 4'd15) begin
      for (int i = 0; i < 8; i++) vars[i] <= chain[i];
    end else if (state == ST_ROUND) begin
      vars[7] <= vars[6]; vars[6] <= vars[5]; vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2]; vars[2] <= vars[1]; vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
    if (rst) begin
      state    <= ST_IDLE;
      word_pos <= '0;
      bit_len  <= '0;
      round    <= '0;
      emit_idx <= '0;
      pad_len  <= 1'b0;
      len_stage <= 1'b0;
      pad_done_q <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= INITIAL_H[i];
    end else begin
      state   <= state_next;
      bit_len <= len_next;
      if (wr_en) word_pos <= word_pos + 4'd1;
      if (state == ST_IDLE && item_valid && item.last) begin
        pad_len   <= 1'b1;
        // four-byte last word still needs the 0x80 word
        len_stage <= (item.count != 3'd4);
      end
      if (state == ST_PAD) begin
        len_stage <= 1'b1;
        if (len_stage && word_pos == 4'd14) pad_done_q <= 1'b1;
      end
      if (state == ST_ROUND) round <= round + 6'd1;
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
      end
      if (state == ST_EMIT && pop) begin
        emit_idx <= emit_idx + 3'd1;
        if (emit_idx == 3'd7) begin
          for (int i = 0; i < 8; i++) chain[i] <= INITIAL_H[i];
          word_pos   <= '0;
          pad_len    <= 1'b0;
          len_stage  <= 1'b0;
          pad_done_q <= 1'b0;
        end
      end
    end
  end

  assign empty       = (state != ST_EMIT);
  assign digest_word = chain[emit_idx];
  assign word_index  = emit_idx;
  assign digest_done = (emit_idx == 3'd7);
endmodule

// File: hdl/sha256_checker.sv
// Port-level checks on the digest channel of the SHA-256 block.
module sha256_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [2:0] word_index,
  input logic       digest_done
);
  a_done_idx: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (digest_done == (word_index == 3'd7))) else $error("done bit");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && word_index != 3'd7) |=> (!empty && word_index == $past(word_index) + 3'd1))
    else $error("index step");
  a_first: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> word_index == 3'd0) else $error("first index");
  a_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && digest_done) |=> empty) else $error("end");
endmodule

bind sha256_message_digest sha256_checker u_chk (
  .clk, .rst, .empty, .pop, .word_index, .digest_done);
